// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== design/scbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan converter package
// Field widths, request codes, register map and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scbl_pkg;

  localparam int LINE_LENGTH_DEF      = 256;
  localparam int SAMPLE_WIDTH_DEF     = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int NUM_LINES = 3;

  localparam int REQ_W     = 2;
  localparam int LINE_W    = 2;
  localparam int COL_IN_W  = 8;
  localparam int SAMP_IN_W = 16;
  localparam int IDX_W     = 20;
  localparam int WGT_IN_W  = 17;
  localparam int PIX_W     = 16;
  localparam int NS_W      = 9;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ROW   = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_NUM_SCANLINES = 1'b0;

  localparam logic [NS_W-1:0] NS_RESET = 9'd255;

endpackage

`default_nettype wire

// ===== design/scan_convert_bilinear_line_buffer_top.sv =====
// ----------------------------------------------------------------------------
// Bilinear scan converter with three rotating line stores
// Load and row items are taken in the idle state and the next item follows at once.
// A pixel holds off further input until its result is registered for output:
// the bit-serial column remainder, four reads of the line store through its
// one read port, three blends on the shared multiplier and the output state.
// Synchronous reset clears control, rotation and num_scanlines (255); the
// line store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scan_convert_bilinear_line_buffer_top
  import scbl_pkg::*;
#(
  parameter int LINE_LENGTH      = LINE_LENGTH_DEF,
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [REQ_W-1:0]        in_req_type,
  input  wire logic [LINE_W-1:0]       in_line_number,
  input  wire logic [COL_IN_W-1:0]     in_column,
  input  wire logic signed [SAMP_IN_W-1:0] in_sample_value,
  input  wire logic [IDX_W-1:0]        in_sample_index,
  input  wire logic [WGT_IN_W-1:0]     in_weight_x,
  input  wire logic [WGT_IN_W-1:0]     in_weight_y,
  input  wire logic                    in_inside_mask,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [PIX_W-1:0]      out_pixel_value,

  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int SW        = SAMPLE_WIDTH;
  localparam int WF        = WEIGHT_FRAC_BITS;
  localparam int WGT_W     = WF + 1;
  localparam int CW        = $clog2(LINE_LENGTH);
  localparam int MEM_DEPTH = NUM_LINES * LINE_LENGTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WCMP_W    = (WGT_IN_W > WGT_W) ? WGT_IN_W : WGT_W;
  localparam int EXT_W     = (SW > PIX_W) ? SW : PIX_W;
  localparam int SEXT_W    = (SW > SAMP_IN_W) ? SW : SAMP_IN_W;
  localparam int CNT_W     = $clog2(IDX_W);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(IDX_W - 1);
  localparam logic [WGT_W-1:0] W_ONE    = {1'b1, {WF{1'b0}}};
  localparam logic [NS_W-1:0]  NS_MAX   =
    (LINE_LENGTH < (1 << NS_W)) ? NS_W'(LINE_LENGTH) : {NS_W{1'b1}};
  localparam logic signed [EXT_W-1:0] PIX_MAX = EXT_W'((1 << (PIX_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] PIX_MIN = EXT_W'(-(1 << (PIX_W - 1)));

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_COL, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_LGO, S_LWAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {L_HU, L_HL, L_V} lsel_t;

  function automatic logic [ADDR_W-1:0] line_addr(input logic [LINE_W-1:0] ln,
                                                  input logic [CW-1:0] c);
    logic [31:0] a;
    a = 32'(ln) * 32'(LINE_LENGTH) + 32'(c);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] ln);
    logic [LINE_W-1:0] n;
    n = (32'(ln) == NUM_LINES - 1) ? '0 : ln + LINE_W'(1);
    return n;
  endfunction

  function automatic logic [WGT_W-1:0] sat_weight(input logic [WGT_IN_W-1:0] wi);
    logic [WCMP_W-1:0] we;
    we = WCMP_W'(wi);
    return (we > WCMP_W'(W_ONE)) ? W_ONE : WGT_W'(wi);
  endfunction

  state_t               state_r, state_nxt;
  lsel_t                lsel_r, lsel_nxt;
  logic [LINE_W-1:0]    rot_r, rot_nxt;
  logic [NS_W-1:0]      num_scan_r, num_scan_nxt;
  logic [NS_W-1:0]      ns_r, ns_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [NS_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WGT_W-1:0]     wx_r, wx_nxt;
  logic [WGT_W-1:0]     wy_r, wy_nxt;
  logic                 mask_r, mask_nxt;
  logic [CW-1:0]        right_r, right_nxt;
  logic signed [SW-1:0] s_ul_r, s_ul_nxt;
  logic signed [SW-1:0] s_ur_r, s_ur_nxt;
  logic signed [SW-1:0] s_ll_r, s_ll_nxt;
  logic signed [SW-1:0] s_lr_r, s_lr_nxt;
  logic signed [SW-1:0] hu_r, hu_nxt;
  logic signed [SW-1:0] hl_r, hl_nxt;
  logic signed [SW-1:0] v_r, v_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [PIX_W-1:0] out_pix_r, out_pix_nxt;

  logic [SW-1:0]        mem [MEM_DEPTH];
  logic [SW-1:0]        rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SW-1:0]        wr_data;
  logic                 wr_en;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 load_ok;
  logic [NS_W-1:0]      ns_eff;
  logic [NS_W:0]        rem_shift;
  logic [NS_W:0]        rem_p1;
  logic [CW-1:0]        col_c;
  logic [LINE_W-1:0]    lo_line;
  logic signed [SEXT_W-1:0] samp_ext;
  logic signed [EXT_W-1:0]  v_ext;
  logic signed [EXT_W-1:0]  v_sat;
  logic signed [PIX_W-1:0]  pix_c;

  logic                 lerp_start;
  logic signed [SW-1:0] lerp_a;
  logic signed [SW-1:0] lerp_b;
  logic [WGT_W-1:0]     lerp_w;
  logic                 lerp_done;
  logic signed [SW-1:0] lerp_res;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_wr  = psel && penable && pwrite;
  assign load_ok = (32'(in_line_number) < NUM_LINES)
                   && (32'(in_column) < 32'(LINE_LENGTH));
  assign ns_eff  = (num_scan_r == '0) ? NS_W'(1)
                   : ((num_scan_r > NS_MAX) ? NS_MAX : num_scan_r);
  assign rem_shift = {rem_r, idx_r[IDX_W-1]};
  assign rem_p1    = {1'b0, rem_r} + (NS_W + 1)'(1);
  assign col_c     = CW'(rem_r);
  assign lo_line   = next_line(rot_r);
  assign samp_ext  = SEXT_W'(in_sample_value);
  assign wr_addr   = line_addr(in_line_number, CW'(in_column));
  assign wr_data   = samp_ext[SW-1:0];

  always_comb begin
    v_ext = EXT_W'(v_r);
    if (v_ext > PIX_MAX) begin
      v_sat = PIX_MAX;
    end else if (v_ext < PIX_MIN) begin
      v_sat = PIX_MIN;
    end else begin
      v_sat = v_ext;
    end
    pix_c = mask_r ? v_sat[PIX_W-1:0] : '0;
  end

  always_comb begin
    case (lsel_r)
      L_HU: begin
        lerp_a = s_ul_r;
        lerp_b = s_ur_r;
        lerp_w = wx_r;
      end
      L_HL: begin
        lerp_a = s_ll_r;
        lerp_b = s_lr_r;
        lerp_w = wx_r;
      end
      default: begin
        lerp_a = hu_r;
        lerp_b = hl_r;
        lerp_w = wy_r;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      S_RD1:   rd_addr = line_addr(rot_r, right_r);
      S_RD2:   rd_addr = line_addr(lo_line, col_c);
      S_RD3:   rd_addr = line_addr(lo_line, right_r);
      default: rd_addr = line_addr(rot_r, col_c);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    lsel_nxt      = lsel_r;
    rot_nxt       = rot_r;
    num_scan_nxt  = num_scan_r;
    ns_nxt        = ns_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    mask_nxt      = mask_r;
    right_nxt     = right_r;
    s_ul_nxt      = s_ul_r;
    s_ur_nxt      = s_ur_r;
    s_ll_nxt      = s_ll_r;
    s_lr_nxt      = s_lr_r;
    hu_nxt        = hu_r;
    hl_nxt        = hl_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    wr_en         = 1'b0;
    lerp_start    = 1'b0;

    if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_NUM_SCANLINES)) begin
      num_scan_nxt = pwdata[NS_W-1:0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_LOAD: begin
              wr_en = load_ok;
            end
            REQ_ROW: begin
              rot_nxt = next_line(rot_r);
            end
            REQ_PIXEL: begin
              idx_nxt   = in_sample_index;
              wx_nxt    = sat_weight(in_weight_x);
              wy_nxt    = sat_weight(in_weight_y);
              mask_nxt  = in_inside_mask;
              ns_nxt    = ns_eff;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_MOD;
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        rem_nxt = (rem_shift >= {1'b0, ns_r}) ? NS_W'(rem_shift - {1'b0, ns_r})
                                              : NS_W'(rem_shift);
        idx_nxt = idx_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        right_nxt = (rem_p1 < {1'b0, ns_r}) ? CW'(rem_p1) : col_c;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        s_ul_nxt  = rd_data_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        s_ur_nxt  = rd_data_r;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        s_ll_nxt  = rd_data_r;
        state_nxt = S_RD4;
      end
      S_RD4: begin
        s_lr_nxt  = rd_data_r;
        lsel_nxt  = L_HU;
        state_nxt = S_LGO;
      end
      S_LGO: begin
        lerp_start = 1'b1;
        state_nxt  = S_LWAIT;
      end
      S_LWAIT: begin
        if (lerp_done) begin
          case (lsel_r)
            L_HU: begin
              hu_nxt    = lerp_res;
              lsel_nxt  = L_HL;
              state_nxt = S_LGO;
            end
            L_HL: begin
              hl_nxt    = lerp_res;
              lsel_nxt  = L_V;
              state_nxt = S_LGO;
            end
            default: begin
              v_nxt     = lerp_res;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = pix_c;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lsel_r      <= L_HU;
      rot_r       <= '0;
      num_scan_r  <= NS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lsel_r      <= lsel_nxt;
      rot_r       <= rot_nxt;
      num_scan_r  <= num_scan_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ns_r      <= ns_nxt;
    idx_r     <= idx_nxt;
    rem_r     <= rem_nxt;
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    mask_r    <= mask_nxt;
    right_r   <= right_nxt;
    s_ul_r    <= s_ul_nxt;
    s_ur_r    <= s_ur_nxt;
    s_ll_r    <= s_ll_nxt;
    s_lr_r    <= s_lr_nxt;
    hu_r      <= hu_nxt;
    hl_r      <= hl_nxt;
    v_r       <= v_nxt;
    out_pix_r <= out_pix_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  scbl_lerp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (lerp_a),
    .b     (lerp_b),
    .w     (lerp_w),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign pready          = 1'b1;
  assign prdata          = (paddr[CFG_ADDR_W-1] == REG_NUM_SCANLINES)
                           ? CFG_DATA_W'(num_scan_r) : '0;

  `ASSERT_CLK(a_pixel_holds_input, clk, rst_n, (in_acc && (in_req_type == REQ_PIXEL)) |=> in_stall)
  `ASSERT_NEVER(a_rot_range, clk, rst_n, rot_r == 2'd3)
  `ASSERT_CLK(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT))
  `ASSERT_CLK(a_col_in_row, clk, rst_n, (state_r == S_RD0) |-> ((rem_r < ns_r) && (32'(right_r) < 32'(ns_r))))

endmodule

`default_nettype wire

// ===== design/scbl_lerp.sv =====
// ----------------------------------------------------------------------------
// Scan converter blend unit
// Two-tap linear blend on one shared multiplier, rounded half away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scbl_lerp
  import scbl_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [SAMPLE_WIDTH-1:0] a,
  input  wire logic signed [SAMPLE_WIDTH-1:0] b,
  input  wire logic [WEIGHT_FRAC_BITS:0]      w,
  output logic                               done,
  output logic signed [SAMPLE_WIDTH-1:0]      res
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int WF     = WEIGHT_FRAC_BITS;
  localparam int WGT_W  = WF + 1;
  localparam int PROD_W = WF + 2 + SW;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [WGT_W-1:0] W_ONE = {1'b1, {WF{1'b0}}};
  localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (WF - 1);

  typedef enum logic [1:0] {P_IDLE, P_MUL_A, P_MUL_B, P_ROUND} phase_t;

  phase_t                   phase_r, phase_nxt;
  logic signed [SW-1:0]     a_r, a_nxt;
  logic signed [SW-1:0]     b_r, b_nxt;
  logic [WGT_W-1:0]         w_r, w_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [SW-1:0]     res_r, res_nxt;
  logic                     done_r, done_nxt;

  logic [WGT_W-1:0]         m_w;
  logic signed [SW-1:0]     m_s;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc_u;
  logic [ACC_W-1:0]         acc_abs;
  logic [ACC_W-1:0]         rnd_mag;
  logic signed [SW-1:0]     res_c;

  always_comb begin
    m_w     = (phase_r == P_MUL_A) ? (W_ONE - w_r) : w_r;
    m_s     = (phase_r == P_MUL_A) ? a_r : b_r;
    prod    = PROD_W'($signed({1'b0, m_w})) * PROD_W'(m_s);
    acc_u   = acc_r;
    acc_abs = acc_u[ACC_W-1] ? (~acc_u + ACC_W'(1)) : acc_u;
    rnd_mag = (acc_abs + HALF) >> WF;
    res_c   = acc_u[ACC_W-1] ? SW'(~rnd_mag + ACC_W'(1)) : SW'(rnd_mag);
  end

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          w_nxt     = w;
          phase_nxt = P_MUL_A;
        end
      end
      P_MUL_A: begin
        acc_nxt   = ACC_W'(prod);
        phase_nxt = P_MUL_B;
      end
      P_MUL_B: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        phase_nxt = P_ROUND;
      end
      P_ROUND: begin
        res_nxt   = res_c;
        done_nxt  = 1'b1;
        phase_nxt = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    w_r   <= w_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== sim/scbl_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel checker for the bilinear scan converter
// Watches the request, pixel and register ports, keeps its own copy of the
// line stores, rotation and scanline count, predicts every pixel and compares
// each pixel transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbl_pixel_checker
  import scbl_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [REQ_W-1:0]            in_req_type,
  input  logic [LINE_W-1:0]           in_line_number,
  input  logic [COL_IN_W-1:0]         in_column,
  input  logic signed [SAMP_IN_W-1:0] in_sample_value,
  input  logic [IDX_W-1:0]            in_sample_index,
  input  logic [WGT_IN_W-1:0]         in_weight_x,
  input  logic [WGT_IN_W-1:0]         in_weight_y,
  input  logic                        in_inside_mask,

  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [PIX_W-1:0]     out_pixel_value,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [CFG_DATA_W-1:0]       pwdata,
  input  logic                        pready,

  output int                          pixels_owed,
  output int                          mismatches
);

  localparam longint W_ONE = longint'(1) << WEIGHT_FRAC_BITS_DEF;

  logic signed [SAMP_IN_W-1:0] line_mem [NUM_LINES][LINE_LENGTH_DEF];
  logic [NS_W-1:0]             ns_cfg;
  int unsigned                 rotation;
  logic signed [PIX_W-1:0]     pixel_q [$];
  logic signed [PIX_W-1:0]     want;
  int                          err_count = 0;

  function automatic longint round_q(input longint acc);
    longint half;
    half = longint'(1) << (WEIGHT_FRAC_BITS_DEF - 1);
    if (acc >= 0) return (acc + half) >>> WEIGHT_FRAC_BITS_DEF;
    return -((half - acc) >>> WEIGHT_FRAC_BITS_DEF);
  endfunction

  function automatic longint lerp_q(input longint a, input longint b, input longint w);
    return round_q((W_ONE - w) * a + w * b);
  endfunction

  function automatic longint clamp_weight(input logic [WGT_IN_W-1:0] w);
    return (longint'(w) > W_ONE) ? W_ONE : longint'(w);
  endfunction

  function automatic logic signed [PIX_W-1:0] blend_pixel(
    input logic [IDX_W-1:0]    idx,
    input logic [WGT_IN_W-1:0] wx,
    input logic [WGT_IN_W-1:0] wy,
    input logic                mask
  );
    int unsigned ns, col, right, up, lo;
    longint      hu, hl, v;
    ns = ns_cfg;
    if (ns == 0) ns = 1;
    if (ns > LINE_LENGTH_DEF) ns = LINE_LENGTH_DEF;
    col   = idx % ns;
    right = (col + 1 < ns) ? col + 1 : col;
    up    = rotation;
    lo    = (rotation + 1) % NUM_LINES;
    hu = lerp_q(line_mem[up][col], line_mem[up][right], clamp_weight(wx));
    hl = lerp_q(line_mem[lo][col], line_mem[lo][right], clamp_weight(wx));
    v  = lerp_q(hu, hl, clamp_weight(wy));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    if (!mask) v = 0;
    return v[PIX_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [PIX_W-1:0] got,
                                 input logic signed [PIX_W-1:0] exp_val);
    $display("MISMATCH at %0t: %s: got %0d, predicted %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_q.delete();
      rotation = 0;
      ns_cfg   = NS_RESET;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] == REG_NUM_SCANLINES) begin
        ns_cfg = pwdata[NS_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("pixel with no prediction pending", out_pixel_value, '0);
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_value !== want) begin
            report_mismatch("pixel_value", out_pixel_value, want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_LOAD: begin
            if (in_line_number < NUM_LINES) begin
              line_mem[in_line_number][in_column] = in_sample_value;
            end
          end
          REQ_ROW: begin
            rotation = (rotation + 1) % NUM_LINES;
          end
          REQ_PIXEL: begin
            pixel_q.push_back(blend_pixel(in_sample_index, in_weight_x, in_weight_y,
                                          in_inside_mask));
          end
          default: begin
          end
        endcase
      end
    end
    pixels_owed <= pixel_q.size();
    mismatches  <= err_count;
  end

endmodule

// ===== sim/scan_convert_bilinear_line_buffer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the bilinear scan converter
// Loads line stores on demand so that no pixel reads an unwritten entry, runs
// a directed set of corner cases and then mixed random traffic over several
// scanline counts, with bursty requests, stalled pixels and a long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_convert_bilinear_line_buffer_top_tb;
  import scbl_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [LINE_W-1:0] LINE_NONE   = 2'd3;
  localparam int                LIMIT       = 1000000;
  localparam int                SETTLE      = 60;
  localparam int                HOLD_PHASE  = 3;
  localparam int                HOLD_CYCLES = 600;
  localparam int                NUM_PHASES  = 8;
  localparam int                PHASE_ITEMS = 240;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [REQ_W-1:0]            in_req_type;
  logic [LINE_W-1:0]           in_line_number;
  logic [COL_IN_W-1:0]         in_column;
  logic signed [SAMP_IN_W-1:0] in_sample_value;
  logic [IDX_W-1:0]            in_sample_index;
  logic [WGT_IN_W-1:0]         in_weight_x;
  logic [WGT_IN_W-1:0]         in_weight_y;
  logic                        in_inside_mask;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [PIX_W-1:0]     out_pixel_value;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [CFG_ADDR_W-1:0]       paddr;
  logic [CFG_DATA_W-1:0]       pwdata;
  logic [CFG_DATA_W-1:0]       prdata;
  logic                        pready;
  int                          pixels_owed;
  int                          mismatches;

  bit                          written [NUM_LINES][LINE_LENGTH_DEF];
  int                          gen_ns = 255;
  int                          gen_rot = 0;
  int                          items_done = 0;
  int                          burst_left = 0;
  bit                          gaps_on = 1'b1;
  int                          phase_no = 0;
  int                          cycle_count;
  logic [NS_W-1:0]             ns_plan [NUM_PHASES] =
    '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd257, 9'd255, 9'd37};

  scan_convert_bilinear_line_buffer_top i_dut (.*);

  scbl_pixel_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WGT_IN_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 17'd65536;
      2:       return 17'd65535;
      3:       return WGT_IN_W'($urandom_range(65537, 131071));
      4:       return WGT_IN_W'($urandom());
      default: return WGT_IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic signed [SAMP_IN_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return SAMP_IN_W'($urandom());
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return IDX_W'($urandom_range(0, 4095) * gen_ns + gen_ns - 1);
      3:       return IDX_W'($urandom_range(0, 1023));
      default: return IDX_W'($urandom());
    endcase
  endfunction

  function automatic logic [COL_IN_W-1:0] rand_column();
    if ($urandom_range(0, 1)) return COL_IN_W'($urandom_range(0, gen_ns - 1));
    return COL_IN_W'($urandom());
  endfunction

  task automatic drive_item(
    input logic [REQ_W-1:0]            req,
    input logic [LINE_W-1:0]           line,
    input logic [COL_IN_W-1:0]         col,
    input logic signed [SAMP_IN_W-1:0] samp,
    input logic [IDX_W-1:0]            idx,
    input logic [WGT_IN_W-1:0]         wx,
    input logic [WGT_IN_W-1:0]         wy,
    input logic                        mask
  );
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_line_number  <= line;
    in_column       <= col;
    in_sample_value <= samp;
    in_sample_index <= idx;
    in_weight_x     <= wx;
    in_weight_y     <= wy;
    in_inside_mask  <= mask;
    do @(posedge clk); while (in_stall);
    items_done++;
    if (req == REQ_LOAD && line < NUM_LINES) begin
      written[line][col] = 1'b1;
    end else if (req == REQ_ROW) begin
      gen_rot = (gen_rot + 1) % NUM_LINES;
    end
  endtask

  task automatic send_load(input logic [LINE_W-1:0] line, input logic [COL_IN_W-1:0] col,
                           input logic signed [SAMP_IN_W-1:0] samp);
    drive_item(REQ_LOAD, line, col, samp, IDX_W'($urandom()), WGT_IN_W'($urandom()),
               WGT_IN_W'($urandom()), 1'($urandom()));
  endtask

  task automatic send_other(input logic [REQ_W-1:0] req);
    drive_item(req, LINE_W'($urandom()), COL_IN_W'($urandom()), SAMP_IN_W'($urandom()),
               IDX_W'($urandom()), WGT_IN_W'($urandom()), WGT_IN_W'($urandom()),
               1'($urandom()));
  endtask

  // load any neighbor entry not yet written before the pixel reads it
  task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [WGT_IN_W-1:0] wx,
                            input logic [WGT_IN_W-1:0] wy, input logic mask);
    int col, right, line, k;
    col   = idx % gen_ns;
    right = (col + 1 < gen_ns) ? col + 1 : col;
    for (k = 0; k < 2; k++) begin
      line = (gen_rot + k) % NUM_LINES;
      if (!written[line][col]) send_load(LINE_W'(line), COL_IN_W'(col), rand_sample());
      if (!written[line][right]) send_load(LINE_W'(line), COL_IN_W'(right), rand_sample());
    end
    drive_item(REQ_PIXEL, LINE_W'($urandom()), COL_IN_W'($urandom()), rand_sample(),
               idx, wx, wy, mask);
  endtask

  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scanlines(input logic [NS_W-1:0] ns);
    logic [CFG_DATA_W-1:0] data;
    data           = $urandom();
    data[NS_W-1:0] = ns;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_SCANLINES, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gen_ns = (ns == 0) ? 1 : (ns > LINE_LENGTH_DEF) ? LINE_LENGTH_DEF : ns;
  endtask

  task automatic run_mixed(input int target);
    int pick;
    while (items_done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_pixel(rand_index(), rand_weight(), rand_weight(), $urandom_range(0, 7) != 0);
      end else if (pick < 78) begin
        send_load(LINE_W'($urandom_range(0, NUM_LINES - 1)), rand_column(), rand_sample());
      end else if (pick < 90) begin
        send_other(REQ_ROW);
      end else if (pick < 95) begin
        send_other(REQ_UNUSED);
      end else begin
        send_load(LINE_NONE, COL_IN_W'($urandom()), SAMP_IN_W'($urandom()));
      end
    end
  endtask

  initial begin
    int ph;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_LOAD;
    in_line_number  = '0;
    in_column       = '0;
    in_sample_value = '0;
    in_sample_index = '0;
    in_weight_x     = '0;
    in_weight_y     = '0;
    in_inside_mask  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    ns_plan[6]      = NS_W'($urandom_range(3, 255));
    ns_plan[7]      = NS_W'($urandom_range(0, 511));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_load(0, 0, 16'sh7FFF);
    send_load(0, 1, 16'sh8000);
    send_load(1, 0, 16'sh8000);
    send_load(1, 1, 16'sh7FFF);
    send_pixel(0, 17'd0, 17'd0, 1'b1);
    send_pixel(0, 17'd65536, 17'd65536, 1'b1);
    send_pixel(0, 17'd32768, 17'd32768, 1'b1);
    send_pixel(0, 17'h1FFFF, 17'd100000, 1'b1);
    send_pixel(0, 17'd12345, 17'd54321, 1'b0);
    send_load(LINE_NONE, 5, 16'sh1234);
    send_other(REQ_UNUSED);
    send_load(0, 254, 16'sd1);
    send_load(1, 254, -16'sd1);
    send_pixel(254, 17'd40000, 17'd30000, 1'b1);
    send_pixel('1, 17'd65535, 17'd1, 1'b1);
    send_other(REQ_ROW);
    send_pixel(0, 17'd20000, 17'd50000, 1'b1);
    send_other(REQ_ROW);
    send_pixel(1, 17'd65536, 17'd32768, 1'b1);
    send_other(REQ_ROW);
    send_pixel(2, 17'd32768, 17'd0, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_scanlines(ns_plan[ph]);
      phase_no = ph + 1;
      gaps_on  = (phase_no != HOLD_PHASE) && ($urandom_range(0, 3) != 0);
      run_mixed(items_done + PHASE_ITEMS);
    end
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int len, mode, k;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (phase_no == HOLD_PHASE && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      for (k = 0; k < len; k++) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 9) < 3);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (k % 4 == 3);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/scbl_pkg.sv
design/scbl_lerp.sv
design/scan_convert_bilinear_line_buffer_top.sv
sim/scbl_pixel_checker.sv
sim/scan_convert_bilinear_line_buffer_top_tb.sv
